// ===== design/hcps_pkg.sv =====
`default_nettype none

package hcps_pkg;

    // geometry of the coefficient and power stores
    localparam int MAX_POINTS = 1024;
    localparam int POW_DEPTH  = MAX_POINTS / 2 + 1;
    localparam int IDX_W      = 10;
    localparam int PT_W       = 11;
    localparam int COEF_W     = 16;
    localparam int POW_W      = 32;
    localparam int SUM_W      = 41;
    localparam int COEF_AW    = $clog2(MAX_POINTS);
    localparam int POW_AW     = $clog2(POW_DEPTH);

    // input and output beat layout
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 1;

    // command codes on the input channel
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    // accepted and dropped, no result
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    // job kinds handed from front to back
    localparam logic [1:0] JOB_LOAD    = 2'd0;
    localparam logic [1:0] JOB_COMPUTE = 2'd1;
    localparam logic [1:0] JOB_READ    = 2'd2;
    localparam logic [1:0] JOB_ERROR   = 2'd3;

    // job queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        index;
        logic signed [COEF_W-1:0] coef;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_chan_t;

    typedef struct packed {
        logic [PT_W-1:0]  n;
        logic [IDX_W-1:0] half;
        logic             even;
    } geom_t;

endpackage

`default_nettype wire

// ===== design/hcps_ram.sv =====
`default_nettype none

module hcps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/hcps_front.sv =====
`default_nettype none

module hcps_front import hcps_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire geom_t                geom,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // bin_index, coefficient
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // command
    output job_chan_t                 head,
    input  wire logic                 pop
);

    job_t               q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    logic [1:0]              cmd;
    logic [IDX_W-1:0]        idx;
    logic signed [COEF_W-1:0] coef;
    job_t                    job_in;
    logic                    beat;
    logic                    push;
    logic                    do_pop;

    assign cmd  = s_axis_tuser;
    assign idx  = s_axis_tdata[IDX_W-1:0];
    assign coef = s_axis_tdata[IDX_W+COEF_W-1:IDX_W];

    // classify the beat and check its index against the current geometry
    always_comb begin
        job_in.index = idx;
        job_in.coef  = coef;
        case (cmd)
            CMD_LOAD:    job_in.kind = ({1'b0, idx} < geom.n) ? JOB_LOAD : JOB_ERROR;
            CMD_COMPUTE: job_in.kind = JOB_COMPUTE;
            CMD_READ:    job_in.kind = (idx <= geom.half) ? JOB_READ : JOB_ERROR;
            default:     job_in.kind = JOB_ERROR;
        endcase
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QDEPTH));
    assign beat          = s_axis_tvalid && s_axis_tready;
    // the ignored command is dropped here
    assign push          = beat && (cmd != CMD_IGNORED);
    assign do_pop        = pop && (count_reg != '0);

    // queue pointers
    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.job   = q_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("job queue count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QCNT_W'(QDEPTH) && !do_pop) |=> (count_reg == QCNT_W'(QDEPTH)))
        else $error("job queue changed while full without pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]))
        else $error("job queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/hcps_back.sv =====
`default_nettype none

module hcps_back import hcps_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire geom_t                geom,
    input  wire job_chan_t            head,
    output logic                      pop,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // bin_power, peak_bin, lowest_bin, power_sum
    output logic [M_TUSER_W-1:0]      m_axis_tuser   // index_error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CA    = 3'd1;
    localparam logic [2:0] ST_CB    = 3'd2;
    localparam logic [2:0] ST_CS    = 3'd3;
    localparam logic [2:0] ST_CP    = 3'd4;
    localparam logic [2:0] ST_CEMIT = 3'd5;
    localparam logic [2:0] ST_RW    = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   bin_reg, bin_next;
    logic [POW_W-1:0]   sq_a_reg, sq_a_next;
    logic [POW_W-1:0]   sq_b_reg, sq_b_next;
    logic [IDX_W-1:0]   peak_reg, peak_next;
    logic [IDX_W-1:0]   low_reg, low_next;
    logic [POW_W-1:0]   max_reg, max_next;
    logic [POW_W-1:0]   min_reg, min_next;
    logic [SUM_W-1:0]   total_reg, total_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [POW_W-1:0]   out_power_reg, out_power_next;
    logic [IDX_W-1:0]   out_peak_reg, out_peak_next;
    logic [IDX_W-1:0]   out_low_reg, out_low_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;
    logic               out_err_reg, out_err_next;

    logic               can_emit;
    logic               emit;

    // memory ports
    logic                coef_we;
    logic                coef_re;
    logic [COEF_AW-1:0]  coef_raddr;
    logic [COEF_W-1:0]   coef_rdata;
    logic                pw_we;
    logic                pw_re;
    logic [POW_W-1:0]    pw_rdata;

    logic signed [COEF_W-1:0] coef_s;
    logic signed [POW_W-1:0]  sq_s;
    logic [POW_W-1:0]         power;
    logic [COEF_AW-1:0]       mirror;
    logic                     single;
    logic                     first_bin;

    assign can_emit = !out_valid_reg || m_axis_tready;

    // square of the word just read, and the bin power (two squares never exceed 2^31)
    assign coef_s    = coef_rdata;
    assign sq_s      = coef_s * coef_s;
    assign power     = sq_a_reg + sq_b_reg;
    assign mirror    = COEF_AW'(geom.n - {1'b0, bin_reg});
    assign single    = (bin_reg == '0) || (geom.even && (bin_reg == geom.half));
    assign first_bin = (bin_reg == IDX_W'(1));

    // job sequencer
    always_comb begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        sq_a_next      = sq_a_reg;
        sq_b_next      = sq_b_reg;
        peak_next      = peak_reg;
        low_next       = low_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        total_next     = total_reg;
        out_power_next = out_power_reg;
        out_peak_next  = out_peak_reg;
        out_low_next   = out_low_reg;
        out_sum_next   = out_sum_reg;
        out_err_next   = out_err_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        coef_we        = 1'b0;
        coef_re        = 1'b0;
        coef_raddr     = bin_reg;
        pw_we          = 1'b0;
        pw_re          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    case (head.job.kind)
                        JOB_LOAD: begin
                            pop     = 1'b1;
                            coef_we = 1'b1;
                        end
                        JOB_COMPUTE: begin
                            pop        = 1'b1;
                            bin_next   = '0;
                            peak_next  = '0;
                            low_next   = '0;
                            max_next   = '0;
                            min_next   = '0;
                            total_next = '0;
                            state_next = ST_CA;
                        end
                        JOB_READ: begin
                            pop        = 1'b1;
                            pw_re      = 1'b1;
                            state_next = ST_RW;
                        end
                        default: begin
                            if (can_emit) begin
                                pop            = 1'b1;
                                emit           = 1'b1;
                                out_power_next = '0;
                                out_peak_next  = '0;
                                out_low_next   = '0;
                                out_sum_next   = '0;
                                out_err_next   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_CA: begin
                coef_re    = 1'b1;
                coef_raddr = bin_reg;
                state_next = ST_CB;
            end
            ST_CB: begin
                sq_a_next  = sq_s;
                coef_re    = 1'b1;
                coef_raddr = mirror;
                state_next = ST_CS;
            end
            ST_CS: begin
                sq_b_next  = single ? '0 : sq_s;
                state_next = ST_CP;
            end
            ST_CP: begin
                pw_we = 1'b1;
                // dc is stored but kept out of the statistics
                if (bin_reg != '0) begin
                    if (first_bin || power > max_reg) begin
                        max_next  = power;
                        peak_next = bin_reg;
                    end
                    if (first_bin || power < min_reg) begin
                        min_next = power;
                        low_next = bin_reg;
                    end
                    total_next = total_reg + SUM_W'(power);
                end
                if (bin_reg == geom.half) begin
                    state_next = ST_CEMIT;
                end else begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = ST_CA;
                end
            end
            ST_CEMIT: begin
                if (can_emit) begin
                    emit           = 1'b1;
                    out_power_next = '0;
                    out_peak_next  = peak_reg;
                    out_low_next   = low_reg;
                    out_sum_next   = total_reg;
                    out_err_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_RW: begin
                if (can_emit) begin
                    emit           = 1'b1;
                    out_power_next = pw_rdata;
                    out_peak_next  = '0;
                    out_low_next   = '0;
                    out_sum_next   = '0;
                    out_err_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb begin
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg       <= bin_next;
        sq_a_reg      <= sq_a_next;
        sq_b_reg      <= sq_b_next;
        peak_reg      <= peak_next;
        low_reg       <= low_next;
        max_reg       <= max_next;
        min_reg       <= min_next;
        total_reg     <= total_next;
        out_power_reg <= out_power_next;
        out_peak_reg  <= out_peak_next;
        out_low_reg   <= out_low_next;
        out_sum_reg   <= out_sum_next;
        out_err_reg   <= out_err_next;
    end

    // coefficient store
    hcps_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_POINTS)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (coef_we),
        .wr_addr (head.job.index[COEF_AW-1:0]),
        .wr_data (head.job.coef),
        .rd_en   (coef_re),
        .rd_addr (coef_raddr),
        .rd_data (coef_rdata)
    );

    // bin power store
    hcps_ram #(
        .WIDTH (POW_W),
        .DEPTH (POW_DEPTH)
    ) u_power_ram (
        .aclk    (aclk),
        .wr_en   (pw_we),
        .wr_addr (bin_reg[POW_AW-1:0]),
        .wr_data (power),
        .rd_en   (pw_re),
        .rd_addr (head.job.index[POW_AW-1:0]),
        .rd_data (pw_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_sum_reg, out_low_reg, out_peak_reg, out_power_reg};
    assign m_axis_tuser  = out_err_reg;

    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pw_we |-> (bin_reg <= geom.half))
        else $error("power write beyond nyquist bin");

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CP) |=> (state_reg == ST_CA || state_reg == ST_CEMIT))
        else $error("bin step left the compute walk");

    a_stats_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CEMIT) |-> (peak_reg >= IDX_W'(1) && peak_reg <= geom.half
                                     && low_reg >= IDX_W'(1) && low_reg <= geom.half
                                     && total_reg >= SUM_W'(max_reg)
                                     && min_reg <= max_reg))
        else $error("compute statistics inconsistent");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("job taken while a job is running");

endmodule

`default_nettype wire

// ===== design/halfcomplex_power_spectrum.sv =====
`default_nettype none
// load and read beats are taken one per cycle while the job queue has room; a read result
// passes the job queue, the power store read and the output register; compute walks bins
// 0..N/2 via CA, CB, CS, CP: the coefficient store has one read port and a bin needs two reads
// a 4-deep job queue takes beats until full, even as the back end computes or a result waits
// reset (aresetn low, synchronous) empties the queue, idles the sequencer, drops a pending
// result and sets point_count to 1024; coefficient and power stores keep their contents

module halfcomplex_power_spectrum import hcps_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [PT_W-1:0]      cfg_wr_data,   // point_count
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // bin_index, coefficient
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // command
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // bin_power, peak_bin, lowest_bin, power_sum
    output logic [M_TUSER_W-1:0]      m_axis_tuser   // index_error
);

    logic [PT_W-1:0] point_count_reg, point_count_next;
    logic [PT_W-1:0] n_eff;
    geom_t           geom;
    job_chan_t       head;
    logic            pop;

    // point count register
    always_comb begin
        point_count_next = cfg_wr_en ? cfg_wr_data : point_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= PT_W'(MAX_POINTS);
        end else begin
            point_count_reg <= point_count_next;
        end
    end

    // effective point count, clamped to 3..MAX_POINTS
    always_comb begin
        if (point_count_reg < PT_W'(3)) begin
            n_eff = PT_W'(3);
        end else if (point_count_reg > PT_W'(MAX_POINTS)) begin
            n_eff = PT_W'(MAX_POINTS);
        end else begin
            n_eff = point_count_reg;
        end
        geom.n    = n_eff;
        geom.half = n_eff[PT_W-1:1];
        geom.even = ~n_eff[0];
    end

    hcps_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .geom          (geom),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .pop           (pop)
    );

    hcps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .geom          (geom),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
